[rtl/ffha_pkg.sv]
`default_nettype none
package ffha_pkg;
  localparam int HeapBytes = 65536;
  localparam int HeaderBytes = 16;
  localparam int OffW = 16;
  localparam int LenW = 17;
  localparam int Depth = HeapBytes / 4;
  localparam int IdxW = 14;

  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree = 1'b1;
  localparam logic StDone = 1'b0;
  localparam logic StNoFit = 1'b1;

  typedef logic [OffW-1:0] off_t;
  typedef logic [LenW-1:0] len_t;
  typedef logic [IdxW-1:0] idx_t;

  typedef struct packed {
    logic             we;
    idx_t             addr;
    logic [LenW:0]    data;
  } hdr_wr_t;
endpackage
`default_nettype wire

[rtl/first_fit_heap_allocator.sv]
`default_nettype none
// First-fit heap allocator with coalescing, 64 KiB heap, 16-byte headers.
// Channels: in_ request taken when start is high and busy is low; out_ result
// shown for one cycle under out_valid, which the receiver cannot hold off;
// cfg_ write port for heap_base, to be written only while idle.
// Each request yields exactly one result. busy stays high until the result
// is shown, so the next request can be taken at the edge that takes it.
// Block headers (taken, length) live in one 16K x 18 memory indexed by
// offset/4; previous-block offsets live in a second 16K x 16 one.
// Allocate reads the headers one at a time along the block chain and
// takes the first free one that fits, writing a remainder header when the
// block is split; at most about 3300 blocks fit in the heap.
// Free ends early for a null, out-of-range or misaligned address and for a
// block that is not live; else it joins a free block before it (unless at
// offset 0) and a free block after it (unless it ends at the heap's top).
// After reset the block runs a clearing pass over the header memory, with
// busy high, and leaves one free block of 65536 bytes.
// The receiver cannot stall; the result is shown for one cycle only.
module first_fit_heap_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_req_type,
  input  wire logic [15:0] in_req_bytes,
  input  wire logic [31:0] in_free_addr,
  output logic             out_valid,
  output logic [31:0]      out_alloc_addr,
  output logic             out_status,
  output logic [16:0]      out_free_bytes,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);
  import ffha_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE,
    S_ARD, S_ACHK, S_ASPL,
    S_FCHK, S_FRD, S_FHDR, S_FPRD, S_FPCHK, S_FNRD, S_FNCHK, S_FWR,
    S_DONE
  } st_t;

  st_t          st_r;
  logic [31:0]  base_r;
  len_t         used_r;
  idx_t         clr_r;
  off_t         pos_r;
  len_t         sz_r, need_r, len_r;
  off_t         prev_r;
  logic [31:0]  faddr_r;
  logic [31:0]  oaddr_r;
  logic         ostat_r;

  hdr_wr_t       hw;
  idx_t          hra;
  logic [LenW:0] hrd;
  logic          pwe;
  idx_t          pwa, pra;
  off_t          pwd, prd;

  len_t          hlen;
  logic          htak;
  logic [31:0]   fpos32;
  len_t          req_sz;
  len_t          walk_pos, nxt_pos;
  off_t          rest_pos;
  logic          fit, whole, nxt_in;

  ffha_hdr_mem u_hdr (.clk, .wr(hw), .rd_addr(hra), .rd_data(hrd));
  ffha_prev_mem u_prev (.clk, .we(pwe), .wr_addr(pwa), .wr_data(pwd),
                        .rd_addr(pra), .rd_data(prd));

  assign hlen = hrd[LenW-1:0];
  assign htak = hrd[LenW];

  assign fpos32 = faddr_r - base_r - 32'(HeaderBytes);
  assign req_sz = len_t'(in_req_bytes) + len_t'(4) - len_t'(in_req_bytes[1:0]);

  assign walk_pos = len_t'(pos_r) + hlen;
  assign nxt_pos = len_t'(pos_r) + len_r;
  assign nxt_in = nxt_pos < len_t'(HeapBytes);
  assign rest_pos = pos_r + need_r[OffW-1:0];
  assign fit = !htak && (hlen >= need_r);
  assign whole = hlen <= sz_r + len_t'(2 * HeaderBytes);

  always_comb begin
    hw  = '0;
    hra = pos_r[OffW-1:2];
    pwe = 1'b0;
    pwa = pos_r[OffW-1:2];
    pwd = pos_r;
    pra = pos_r[OffW-1:2];
    unique case (st_r)
      S_CLR: begin
        hw.we = 1'b1;
        hw.addr = clr_r;
        hw.data = (clr_r == '0) ? {1'b0, len_t'(HeapBytes)} : '0;
      end
      S_ACHK: begin
        if (hlen != '0 && fit) begin
          hw.we = 1'b1;
          hw.addr = pos_r[OffW-1:2];
          if (whole) begin
            hw.data = {1'b1, hlen};
          end else begin
            hw.data = {1'b1, need_r};
            pwe = 1'b1;
            pwa = rest_pos[OffW-1:2];
            pwd = pos_r;
          end
        end
      end
      S_ASPL: begin
        hw.we = 1'b1;
        hw.addr = rest_pos[OffW-1:2];
        hw.data = {1'b0, len_r - need_r};
        pwe = nxt_in;
        pwa = nxt_pos[OffW-1:2];
        pwd = rest_pos;
      end
      S_FHDR: begin
        if (hlen != '0 && htak) begin
          hw.we = 1'b1;
          hw.addr = pos_r[OffW-1:2];
          hw.data = {1'b0, hlen};
        end
      end
      S_FPRD: hra = prev_r[OffW-1:2];
      S_FPCHK: begin
        if (!htak) begin
          hw.we = 1'b1;
          hw.addr = pos_r[OffW-1:2];
          hw.data = '0;
        end
      end
      S_FNRD: hra = nxt_pos[OffW-1:2];
      S_FNCHK: begin
        if (!htak) begin
          hw.we = 1'b1;
          hw.addr = nxt_pos[OffW-1:2];
          hw.data = '0;
        end
      end
      S_FWR: begin
        hw.we = 1'b1;
        hw.addr = pos_r[OffW-1:2];
        hw.data = {1'b0, len_r};
        pwe = nxt_in;
        pwa = nxt_pos[OffW-1:2];
        pwd = pos_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      clr_r <= '0;
      base_r <= '0;
      used_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) base_r <= cfg_wdata;
      unique case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == idx_t'(Depth - 1)) st_r <= S_IDLE;
        end
        S_IDLE: if (start) begin
          faddr_r <= in_free_addr;
          sz_r <= req_sz;
          need_r <= req_sz + len_t'(HeaderBytes);
          pos_r <= '0;
          oaddr_r <= '0;
          ostat_r <= StDone;
          st_r <= (in_req_type == ReqFree) ? S_FCHK : S_ARD;
        end
        S_ARD: st_r <= S_ACHK;
        S_ACHK: begin
          if (hlen == '0) begin
            ostat_r <= StNoFit;
            st_r <= S_DONE;
          end else if (fit) begin
            oaddr_r <= base_r + 32'(pos_r) + 32'(HeaderBytes);
            len_r <= hlen;
            if (whole) begin
              used_r <= used_r + hlen;
              st_r <= S_DONE;
            end else begin
              used_r <= used_r + need_r;
              st_r <= S_ASPL;
            end
          end else if (walk_pos >= len_t'(HeapBytes)) begin
            ostat_r <= StNoFit;
            st_r <= S_DONE;
          end else begin
            pos_r <= walk_pos[OffW-1:0];
            st_r <= S_ARD;
          end
        end
        S_ASPL: st_r <= S_DONE;
        S_FCHK: begin
          if (faddr_r == '0 || fpos32 >= 32'(HeapBytes) || fpos32[1:0] != 2'b00) begin
            st_r <= S_DONE;
          end else begin
            pos_r <= fpos32[OffW-1:0];
            st_r <= S_FRD;
          end
        end
        S_FRD: st_r <= S_FHDR;
        S_FHDR: begin
          if (hlen == '0 || !htak) begin
            st_r <= S_DONE;
          end else begin
            used_r <= used_r - hlen;
            len_r <= hlen;
            prev_r <= prd;
            st_r <= (pos_r == '0) ? S_FNRD : S_FPRD;
          end
        end
        S_FPRD: st_r <= S_FPCHK;
        S_FPCHK: begin
          if (!htak) begin
            len_r <= len_r + hlen;
            pos_r <= prev_r;
          end
          st_r <= S_FNRD;
        end
        S_FNRD: st_r <= nxt_in ? S_FNCHK : S_FWR;
        S_FNCHK: begin
          if (!htak) len_r <= len_r + hlen;
          st_r <= S_FWR;
        end
        S_FWR: st_r <= S_DONE;
        S_DONE: begin
          out_valid <= 1'b1;
          out_alloc_addr <= oaddr_r;
          out_status <= ostat_r;
          out_free_bytes <= len_t'(HeapBytes) - used_r;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (st_r != S_IDLE);

  a_strobe_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid);
  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy);
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy);
  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= len_t'(HeapBytes));
endmodule
`default_nettype wire

[rtl/ffha_hdr_mem.sv]
`default_nettype none
module ffha_hdr_mem (
  input  wire logic                 clk,
  input  wire ffha_pkg::hdr_wr_t    wr,
  input  wire ffha_pkg::idx_t       rd_addr,
  output logic [ffha_pkg::LenW:0]   rd_data
);
  import ffha_pkg::*;
  logic [LenW:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr.we) mem[wr.addr] <= wr.data;
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

[rtl/ffha_prev_mem.sv]
`default_nettype none
module ffha_prev_mem (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire ffha_pkg::idx_t  wr_addr,
  input  wire ffha_pkg::off_t  wr_data,
  input  wire ffha_pkg::idx_t  rd_addr,
  output ffha_pkg::off_t       rd_data
);
  import ffha_pkg::*;
  off_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire
